// ----- rtl/aop_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_pkg
// Types, codes and sizes shared by the object pool front, back and top level.
// ----------------------------------------------------------------------------
package aop_pkg;

	localparam int POOL_SIZE_DEF = 64;
	localparam int SLOT_FW       = 6;
	localparam int COORD_W       = 16;
	localparam int AGE_W         = 11;
	localparam int LIFETIME_W    = 10;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 10'd500;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_KILL   = 2'd2;

	typedef enum logic [1:0] {
		CMD_CREATE,
		CMD_TICK,
		CMD_KILL,
		CMD_KILL_BAD
	} cmd_kind_t;

	typedef enum logic [2:0] {
		RK_CREATED,
		RK_FULL,
		RK_POS,
		RK_NONE_LIVE,
		RK_KILLED,
		RK_KILL_IGNORED
	} res_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CREATE,
		ST_SCAN,
		ST_UPDATE
	} st_t;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [SLOT_FW-1:0]        slot;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
	} req_t;

	typedef struct packed {
		res_kind_t                 kind;
		logic [SLOT_FW-1:0]        report_slot;
		logic signed [COORD_W-1:0] report_x;
		logic signed [COORD_W-1:0] report_y;
		logic                      last;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t                 kind;
		logic [SLOT_FW-1:0]        slot;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] vel_x;
		logic signed [COORD_W-1:0] vel_y;
		logic [AGE_W-1:0]          age;
	} obj_t;

endpackage

// ----- rtl/aop_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module aop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/aop_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_front
// Request intake: decodes each word into a command and queues it for the back, but drops a word with an unknown opcode.
// ----------------------------------------------------------------------------
module aop_front #(
	parameter int POOL_SIZE = aop_pkg::POOL_SIZE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  aop_pkg::req_t req,
	output logic          q_valid,
	output aop_pkg::cmd_t q_head,
	input  logic          q_pop
);

	localparam int PTR_W  = $clog2(aop_pkg::QUEUE_DEPTH);
	localparam int FILL_W = $clog2(aop_pkg::QUEUE_DEPTH + 1);

	aop_pkg::cmd_t     cmd;
	logic              drop;
	logic              push;
	aop_pkg::cmd_t     mem_q [aop_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	always_comb begin
		cmd.kind  = aop_pkg::CMD_CREATE;
		cmd.slot  = req.slot;
		cmd.pos_x = req.pos_x;
		cmd.pos_y = req.pos_y;
		cmd.vel_x = req.vel_x;
		cmd.vel_y = req.vel_y;
		drop      = 1'b0;
		case (req.opcode)
			aop_pkg::OP_CREATE: begin
				cmd.kind = aop_pkg::CMD_CREATE;
			end
			aop_pkg::OP_TICK: begin
				cmd.kind = aop_pkg::CMD_TICK;
			end
			aop_pkg::OP_KILL: begin
				if (7'(req.slot) < 7'(POOL_SIZE)) begin
					cmd.kind = aop_pkg::CMD_KILL;
				end else begin
					cmd.kind = aop_pkg::CMD_KILL_BAD;
				end
			end
			default: begin
				drop = 1'b1;
			end
		endcase
	end

	assign req_ready = (fill_q != FILL_W'(aop_pkg::QUEUE_DEPTH));
	assign push      = req_valid && req_ready && !drop;
	assign q_valid   = (fill_q != '0);
	assign q_head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(aop_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(aop_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + PTR_W'(1);
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (q_pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

// ----- rtl/aop_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aop_back
// Command execution: free-slot stack, object store, tick sweep, result register.
// ----------------------------------------------------------------------------
module aop_back #(
	parameter int POOL_SIZE = aop_pkg::POOL_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  aop_pkg::cmd_t                     q_head,
	output logic                              q_pop,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [aop_pkg::LIFETIME_W-1:0]    cfg_data,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output aop_pkg::rsp_t                     rsp
);

	localparam int SLOT_W = $clog2(POOL_SIZE);
	localparam int CNT_W  = $clog2(POOL_SIZE + 1);
	localparam int OBJ_W  = $bits(aop_pkg::obj_t);

	aop_pkg::st_t                   state_q;
	aop_pkg::st_t                   state_d;
	logic [SLOT_W-1:0]              scan_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               low_q;
	logic [POOL_SIZE-1:0]           live_q;
	logic [aop_pkg::LIFETIME_W-1:0] lifetime_q;
	logic                           rsp_valid_q;
	aop_pkg::rsp_t                  rsp_q;

	logic                           out_free;
	logic [CNT_W-1:0]               pop_full;
	logic [SLOT_W-1:0]              pop_idx;
	logic                           pop_fresh;
	logic [SLOT_W-1:0]              push_idx;
	logic [SLOT_W-1:0]              kill_idx;
	logic [SLOT_W-1:0]              grant_slot;
	logic                           any_live;
	logic                           more;
	aop_pkg::obj_t                  obj_cur;
	logic [OBJ_W-1:0]               obj_rd_data;
	logic signed [aop_pkg::COORD_W-1:0] nx;
	logic signed [aop_pkg::COORD_W-1:0] ny;
	logic [aop_pkg::AGE_W-1:0]      age_nx;
	logic                           expire;
	logic [SLOT_W-1:0]              stk_rd_data;

	logic                           emit;
	aop_pkg::rsp_t                  emit_res;
	logic                           obj_rd_en;
	logic                           obj_wr_en;
	logic [SLOT_W-1:0]              obj_wr_addr;
	aop_pkg::obj_t                  obj_wr_data;
	logic                           stk_rd_en;
	logic                           stk_wr_en;
	logic [SLOT_W-1:0]              stk_wr_data;
	logic                           live_set;
	logic                           live_clr;
	logic [SLOT_W-1:0]              live_idx;
	logic                           cnt_inc;
	logic                           cnt_dec;
	logic                           low_upd;
	logic                           scan_clr;
	logic                           scan_inc;

	assign cfg_ready  = 1'b1;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign out_free   = !rsp_valid_q || rsp_ready;
	assign pop_full   = cnt_q - CNT_W'(1);
	assign pop_idx    = pop_full[SLOT_W-1:0];
	assign pop_fresh  = (pop_full < low_q);
	assign push_idx   = cnt_q[SLOT_W-1:0];
	assign kill_idx   = q_head.slot[SLOT_W-1:0];
	assign grant_slot = pop_fresh ? (SLOT_W'(POOL_SIZE - 1) - pop_idx) : stk_rd_data;
	assign any_live   = |live_q;

	assign obj_cur    = aop_pkg::obj_t'(obj_rd_data);
	assign nx         = obj_cur.pos_x + obj_cur.vel_x;
	assign ny         = obj_cur.pos_y + obj_cur.vel_y;
	assign age_nx     = obj_cur.age + aop_pkg::AGE_W'(1);
	assign expire     = (age_nx > aop_pkg::AGE_W'(lifetime_q));

	always_comb begin
		more = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (live_q[i] && (i > int'(scan_q))) begin
				more = 1'b1;
			end
		end
	end

	aop_ram #(
		.WIDTH(OBJ_W),
		.DEPTH(POOL_SIZE)
	) u_obj_ram (
		.clk    (clk),
		.wr_en  (obj_wr_en),
		.wr_addr(obj_wr_addr),
		.wr_data(obj_wr_data),
		.rd_en  (obj_rd_en),
		.rd_addr(scan_q),
		.rd_data(obj_rd_data)
	);

	aop_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(POOL_SIZE)
	) u_stk_ram (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(push_idx),
		.wr_data(stk_wr_data),
		.rd_en  (stk_rd_en),
		.rd_addr(pop_idx),
		.rd_data(stk_rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			aop_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_head.kind == aop_pkg::CMD_CREATE && cnt_q != '0) begin
						state_d = aop_pkg::ST_CREATE;
					end else if (q_head.kind == aop_pkg::CMD_TICK && any_live) begin
						state_d = aop_pkg::ST_SCAN;
					end
				end
			end
			aop_pkg::ST_CREATE: begin
				if (out_free) begin
					state_d = aop_pkg::ST_IDLE;
				end
			end
			aop_pkg::ST_SCAN: begin
				if (live_q[scan_q]) begin
					state_d = aop_pkg::ST_UPDATE;
				end
			end
			aop_pkg::ST_UPDATE: begin
				if (out_free) begin
					state_d = more ? aop_pkg::ST_SCAN : aop_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aop_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop                = 1'b0;
		emit                 = 1'b0;
		emit_res.kind        = aop_pkg::RK_CREATED;
		emit_res.report_slot = '0;
		emit_res.report_x    = '0;
		emit_res.report_y    = '0;
		emit_res.last        = 1'b1;
		obj_rd_en            = 1'b0;
		obj_wr_en            = 1'b0;
		obj_wr_addr          = scan_q;
		obj_wr_data.pos_x    = nx;
		obj_wr_data.pos_y    = ny;
		obj_wr_data.vel_x    = obj_cur.vel_x;
		obj_wr_data.vel_y    = obj_cur.vel_y;
		obj_wr_data.age      = age_nx;
		stk_rd_en            = 1'b0;
		stk_wr_en            = 1'b0;
		stk_wr_data          = scan_q;
		live_set             = 1'b0;
		live_clr             = 1'b0;
		live_idx             = scan_q;
		cnt_inc              = 1'b0;
		cnt_dec              = 1'b0;
		low_upd              = 1'b0;
		scan_clr             = 1'b0;
		scan_inc             = 1'b0;
		case (state_q)
			aop_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (q_head.kind)
						aop_pkg::CMD_CREATE: begin
							if (cnt_q == '0) begin
								if (out_free) begin
									emit          = 1'b1;
									emit_res.kind = aop_pkg::RK_FULL;
									q_pop         = 1'b1;
								end
							end else begin
								stk_rd_en = 1'b1;
							end
						end
						aop_pkg::CMD_TICK: begin
							if (!any_live) begin
								if (out_free) begin
									emit          = 1'b1;
									emit_res.kind = aop_pkg::RK_NONE_LIVE;
									q_pop         = 1'b1;
								end
							end else begin
								scan_clr = 1'b1;
							end
						end
						aop_pkg::CMD_KILL: begin
							if (out_free) begin
								emit                 = 1'b1;
								q_pop                = 1'b1;
								emit_res.report_slot = q_head.slot;
								if (live_q[kill_idx]) begin
									emit_res.kind = aop_pkg::RK_KILLED;
									live_clr      = 1'b1;
									live_idx      = kill_idx;
									stk_wr_en     = 1'b1;
									stk_wr_data   = kill_idx;
									cnt_inc       = 1'b1;
								end else begin
									emit_res.kind = aop_pkg::RK_KILL_IGNORED;
								end
							end
						end
						default: begin
							if (out_free) begin
								emit                 = 1'b1;
								q_pop                = 1'b1;
								emit_res.kind        = aop_pkg::RK_KILL_IGNORED;
								emit_res.report_slot = q_head.slot;
							end
						end
					endcase
				end
			end
			aop_pkg::ST_CREATE: begin
				if (out_free) begin
					emit                 = 1'b1;
					q_pop                = 1'b1;
					emit_res.kind        = aop_pkg::RK_CREATED;
					emit_res.report_slot = aop_pkg::SLOT_FW'(grant_slot);
					obj_wr_en            = 1'b1;
					obj_wr_addr          = grant_slot;
					obj_wr_data.pos_x    = q_head.pos_x;
					obj_wr_data.pos_y    = q_head.pos_y;
					obj_wr_data.vel_x    = q_head.vel_x;
					obj_wr_data.vel_y    = q_head.vel_y;
					obj_wr_data.age      = '0;
					live_set             = 1'b1;
					live_idx             = grant_slot;
					cnt_dec              = 1'b1;
					low_upd              = pop_fresh;
				end
			end
			aop_pkg::ST_SCAN: begin
				if (live_q[scan_q]) begin
					obj_rd_en = 1'b1;
				end else begin
					scan_inc = 1'b1;
				end
			end
			aop_pkg::ST_UPDATE: begin
				if (out_free) begin
					emit                 = 1'b1;
					emit_res.kind        = aop_pkg::RK_POS;
					emit_res.report_slot = aop_pkg::SLOT_FW'(scan_q);
					emit_res.report_x    = nx;
					emit_res.report_y    = ny;
					emit_res.last        = !more;
					obj_wr_en            = 1'b1;
					if (expire) begin
						live_clr  = 1'b1;
						stk_wr_en = 1'b1;
						cnt_inc   = 1'b1;
					end
					if (more) begin
						scan_inc = 1'b1;
					end else begin
						q_pop = 1'b1;
					end
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aop_pkg::ST_IDLE;
			scan_q      <= '0;
			cnt_q       <= CNT_W'(POOL_SIZE);
			low_q       <= CNT_W'(POOL_SIZE);
			live_q      <= '0;
			lifetime_q  <= aop_pkg::LIFETIME_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (scan_clr) begin
				scan_q <= '0;
			end else if (scan_inc) begin
				scan_q <= scan_q + SLOT_W'(1);
			end
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= pop_full;
			end
			if (low_upd) begin
				low_q <= pop_full;
			end
			if (live_set) begin
				live_q[live_idx] <= 1'b1;
			end else if (live_clr) begin
				live_q[live_idx] <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				lifetime_q <= cfg_data;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_res;
		end
	end

	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(live_q) + int'(cnt_q)) == POOL_SIZE)
		else $error("live slots and free slots do not add up to the pool size");

	a_low_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= low_q)
		else $error("free count below its low-water mark");

	a_update_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aop_pkg::ST_UPDATE |-> live_q[scan_q])
		else $error("updating a slot that is not live");

	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aop_pkg::ST_IDLE && state_d == aop_pkg::ST_SCAN) |=> scan_q == '0)
		else $error("sweep did not start at slot zero");

endmodule

// ----- rtl/aging_object_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_object_pool
// Pool of moving objects with a free-slot stack, per-tick motion and aging.
// ----------------------------------------------------------------------------
// Requests enter a two-word command queue, so the block takes new words while
// the queue has room, also while a command runs or a result waits on rsp; a
// word that finds the queue empty reaches the back the cycle after it is
// accepted. A create reads the free-slot stack, then writes the object; a kill,
// a create into a full pool and a tick with nothing live finish from the idle
// state. A tick clears the scan index, then sweeps the slots from zero up to
// the highest live slot, reading each live slot's object from the object
// memory and writing it back moved and aged. No clearing pass runs after
// reset: a low-water mark on the free count serves the reset contents of the
// free-slot stack. Each result word also waits while rsp is stalled.
// ----------------------------------------------------------------------------
module aging_object_pool #(
	parameter int POOL_SIZE = aop_pkg::POOL_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  aop_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output aop_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [aop_pkg::LIFETIME_W-1:0] cfg_data
);

	logic          q_valid;
	aop_pkg::cmd_t q_head;
	logic          q_pop;

	aop_front #(
		.POOL_SIZE(POOL_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	aop_back #(
		.POOL_SIZE(POOL_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
